>>> rtl/core/wcr_pkg.sv
`default_nettype none

package wcr_pkg;

  // Register file layout
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_KERNEL_H  = 3'd0,
    REG_KERNEL_W  = 3'd1,
    REG_STRIDE_H  = 3'd2,
    REG_STRIDE_W  = 3'd3,
    REG_PAD_H     = 3'd4,
    REG_PAD_W     = 3'd5,
    REG_IN_HEIGHT = 3'd6,
    REG_IN_WIDTH  = 3'd7
  } reg_idx_t;

  // Field widths
  localparam int KER_BITS  = 4;
  localparam int STR_BITS  = 4;
  localparam int PAD_BITS  = 3;
  localparam int SIZE_BITS = 13;
  localparam int IDX_BITS  = 12;
  localparam int VAL_BITS  = 32;
  localparam int TAP_BITS  = 4;
  localparam int CNT_BITS  = 2 * TAP_BITS;

  // Reset values
  localparam logic [KER_BITS-1:0]  KERNEL_RST = 4'd3;
  localparam logic [STR_BITS-1:0]  STRIDE_RST = 4'd1;
  localparam logic [PAD_BITS-1:0]  PAD_RST    = 3'd1;
  localparam logic [SIZE_BITS-1:0] SIZE_RST   = 13'd256;

  // Divider geometry: dividend is 2*|value|*full + den (< 2^40), divisor 2*den
  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = CNT_BITS + 1;
  localparam int DIV_STEP  = 4;

  // Default build options
  localparam int ROW_DIL_DEF   = 1;
  localparam int COL_DIL_DEF   = 1;
  localparam int MEAN_ONLY_DEF = 0;

  typedef struct packed {
    logic valid;
    logic neg;
  } div_tag_t;

  // Count dilated taps that fit in a span, held at a minimum of one
  function automatic logic [TAP_BITS-1:0] tap_count(input logic [TAP_BITS-1:0] span,
                                                    input int dil);
    logic [TAP_BITS-1:0] cnt;
    cnt = '0;
    for (int k = 0; k < 15; k++) begin
      if (k * dil < int'(span)) begin
        cnt = cnt + TAP_BITS'(1);
      end
    end
    if (cnt == '0) begin
      cnt = TAP_BITS'(1);
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/wcr_div_pipe.sv
`default_nettype none

module wcr_div_pipe #(
  parameter int NUM_W = wcr_pkg::DIV_NUM_W,
  parameter int DEN_W = wcr_pkg::DIV_DEN_W,
  parameter int STEP  = wcr_pkg::DIV_STEP
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wcr_pkg::div_tag_t in_tag,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  output wcr_pkg::div_tag_t      out_tag,
  output logic [NUM_W-1:0]       out_quo
);

  localparam int NS = NUM_W / STEP;

  // Index 0 is the input; index s holds the registers after stage s
  wcr_pkg::div_tag_t  tag_r [0:NS];
  logic [NUM_W-1:0]   w_r   [0:NS];
  logic [DEN_W-1:0]   rem_r [0:NS];
  logic [DEN_W-1:0]   den_r [0:NS];

  assign tag_r[0] = in_tag;
  assign w_r[0]   = in_num;
  assign rem_r[0] = '0;
  assign den_r[0] = in_den;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [NUM_W-1:0] w_nxt;
    logic [DEN_W-1:0] rem_nxt;

    // Restoring division, STEP quotient bits per stage
    always_comb begin
      logic [DEN_W:0] rx;
      logic [NUM_W-1:0] w;
      logic [DEN_W-1:0] r;
      w = w_r[s];
      r = rem_r[s];
      rx = '0;
      for (int j = 0; j < STEP; j++) begin
        rx = {r, w[NUM_W-1]};
        w  = {w[NUM_W-2:0], 1'b0};
        if (rx >= {1'b0, den_r[s]}) begin
          rx   = rx - {1'b0, den_r[s]};
          w[0] = 1'b1;
        end
        r = rx[DEN_W-1:0];
      end
      w_nxt   = w;
      rem_nxt = r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[s+1] <= '0;
      end else begin
        tag_r[s+1] <= tag_r[s];
      end
    end

    always_ff @(posedge clk) begin
      w_r[s+1]   <= w_nxt;
      rem_r[s+1] <= rem_nxt;
      den_r[s+1] <= den_r[s];
    end
  end

  assign out_tag = tag_r[NS];
  assign out_quo = w_r[NS];

`ifndef NO_ASSERTIONS
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r[NS].valid |-> rem_r[NS] < den_r[NS])
    else $error("divider remainder not below divisor");

  a_valid_latency: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r[NS].valid |-> $past(in_tag.valid, NS))
    else $error("divider output without matching input");

  a_den_carried: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r[NS].valid |-> den_r[NS] == $past(in_den, NS))
    else $error("divisor corrupted along divider pipe");
`endif

endmodule

`default_nettype wire

>>> rtl/core/window_coverage_rectify.sv
// Pipeline from the accepting edge to the result: 4 front stages, a 10-stage pipelined
//   divider at 4 quotient bits each, and 1 output stage.
// Throughput: one request per cycle; busy is low whenever reset is released.
// The receiver cannot stall: each result shows on out_value_out for one cycle with out_valid.
// Reset (synchronous, rst_n low) loads the register defaults and drops every item in flight;
//   busy stays high while reset is held.
`default_nettype none

module window_coverage_rectify #(
  parameter int ROW_DIL   = wcr_pkg::ROW_DIL_DEF,
  parameter int COL_DIL   = wcr_pkg::COL_DIL_DEF,
  parameter int MEAN_ONLY = wcr_pkg::MEAN_ONLY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [wcr_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [wcr_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [wcr_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                     pready,
  // Request channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [wcr_pkg::VAL_BITS-1:0] in_value_in,
  input  wire logic [wcr_pkg::IDX_BITS-1:0]        in_out_row,
  input  wire logic [wcr_pkg::IDX_BITS-1:0]        in_out_col,
  // Result channel
  output logic                                     out_valid,
  output logic signed [wcr_pkg::VAL_BITS-1:0]      out_value_out
);

  localparam int DIL_H = (ROW_DIL < 1) ? 1 : ROW_DIL;
  localparam int DIL_W = (COL_DIL < 1) ? 1 : COL_DIL;
  localparam int NUM_W = wcr_pkg::DIV_NUM_W;
  localparam int DEN_W = wcr_pkg::DIV_DEN_W;
  localparam int LAT   = 5 + NUM_W / wcr_pkg::DIV_STEP;
  localparam int TB    = wcr_pkg::TAP_BITS;
  localparam int CB    = wcr_pkg::CNT_BITS;
  localparam int VB    = wcr_pkg::VAL_BITS;
  localparam int SB    = wcr_pkg::SIZE_BITS;

  // ---------------------------------------------------------------------------
  // Register file. Users must write it only while no request is in flight (not enforced).
  // ---------------------------------------------------------------------------
  logic [wcr_pkg::KER_BITS-1:0]  kernel_h_r, kernel_w_r;
  logic [wcr_pkg::STR_BITS-1:0]  stride_h_r, stride_w_r;
  logic [wcr_pkg::PAD_BITS-1:0]  pad_h_r, pad_w_r;
  logic [SB-1:0]                 in_height_r, in_width_r;
  logic                          cfg_wr;
  wcr_pkg::reg_idx_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = wcr_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_h_r  <= wcr_pkg::KERNEL_RST;
      kernel_w_r  <= wcr_pkg::KERNEL_RST;
      stride_h_r  <= wcr_pkg::STRIDE_RST;
      stride_w_r  <= wcr_pkg::STRIDE_RST;
      pad_h_r     <= wcr_pkg::PAD_RST;
      pad_w_r     <= wcr_pkg::PAD_RST;
      in_height_r <= wcr_pkg::SIZE_RST;
      in_width_r  <= wcr_pkg::SIZE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        wcr_pkg::REG_KERNEL_H:  kernel_h_r  <= pwdata[wcr_pkg::KER_BITS-1:0];
        wcr_pkg::REG_KERNEL_W:  kernel_w_r  <= pwdata[wcr_pkg::KER_BITS-1:0];
        wcr_pkg::REG_STRIDE_H:  stride_h_r  <= pwdata[wcr_pkg::STR_BITS-1:0];
        wcr_pkg::REG_STRIDE_W:  stride_w_r  <= pwdata[wcr_pkg::STR_BITS-1:0];
        wcr_pkg::REG_PAD_H:     pad_h_r     <= pwdata[wcr_pkg::PAD_BITS-1:0];
        wcr_pkg::REG_PAD_W:     pad_w_r     <= pwdata[wcr_pkg::PAD_BITS-1:0];
        wcr_pkg::REG_IN_HEIGHT: in_height_r <= pwdata[SB-1:0];
        wcr_pkg::REG_IN_WIDTH:  in_width_r  <= pwdata[SB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      wcr_pkg::REG_KERNEL_H:  prdata = 32'(kernel_h_r);
      wcr_pkg::REG_KERNEL_W:  prdata = 32'(kernel_w_r);
      wcr_pkg::REG_STRIDE_H:  prdata = 32'(stride_h_r);
      wcr_pkg::REG_STRIDE_W:  prdata = 32'(stride_w_r);
      wcr_pkg::REG_PAD_H:     prdata = 32'(pad_h_r);
      wcr_pkg::REG_PAD_W:     prdata = 32'(pad_w_r);
      wcr_pkg::REG_IN_HEIGHT: prdata = 32'(in_height_r);
      wcr_pkg::REG_IN_WIDTH:  prdata = 32'(in_width_r);
      default:                prdata = '0;
    endcase
  end

  // A zero kernel register acts as a kernel of one
  logic [TB-1:0] kk_h, kk_w;
  assign kk_h = (kernel_h_r == '0) ? TB'(1) : kernel_h_r;
  assign kk_w = (kernel_w_r == '0) ? TB'(1) : kernel_w_r;

  // Full tap counts of the configured kernel; the product travels with each
  // request from stage 1 on, so a request right after a write sees the new value.
  logic [TB-1:0] full_h, full_w;
  assign full_h = wcr_pkg::tap_count(kk_h, DIL_H);
  assign full_w = wcr_pkg::tap_count(kk_w, DIL_W);

  // ---------------------------------------------------------------------------
  // Request accept. No backpressure inside, so only reset holds requests off.
  // ---------------------------------------------------------------------------
  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Clip one axis of the window to the image and return the covered span
  // (zero when the window misses the image entirely; never above the kernel).
  function automatic logic [TB-1:0] clip_span(input logic signed [16:0] st,
                                              input logic [TB-1:0] kk,
                                              input logic [wcr_pkg::PAD_BITS-1:0] pad,
                                              input logic [SB-1:0] size);
    logic signed [17:0] s0, e0, lim, sz, span;
    s0   = 18'(st);
    e0   = s0 + $signed({14'b0, kk});
    lim  = $signed({5'b0, size}) + $signed({15'b0, pad});
    sz   = $signed({5'b0, size});
    if (e0 > lim) begin
      e0 = lim;
    end
    if (s0 < 0) begin
      s0 = '0;
    end
    if (e0 > sz) begin
      e0 = sz;
    end
    span = e0 - s0;
    return (span > 0) ? span[TB-1:0] : '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stage 1: window start per axis, sign and magnitude of the sample, and the
  // full tap product that scales it (one when MEAN_ONLY is set).
  // ---------------------------------------------------------------------------
  logic                s1_valid_r;
  logic signed [16:0]  s1_start_h_r, s1_start_w_r;
  logic [VB-1:0]       s1_mag_r;
  logic                s1_neg_r;
  logic [CB-1:0]       s1_full_r;

  logic [15:0]         prod_h, prod_w;
  assign prod_h = 16'(in_out_row) * 16'(stride_h_r);
  assign prod_w = 16'(in_out_col) * 16'(stride_w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_start_h_r <= $signed({1'b0, prod_h}) - $signed({14'b0, pad_h_r});
    s1_start_w_r <= $signed({1'b0, prod_w}) - $signed({14'b0, pad_w_r});
    s1_neg_r     <= in_value_in[VB-1];
    // Most negative input keeps its own bit pattern as magnitude 2^31
    s1_mag_r     <= in_value_in[VB-1] ? VB'(-in_value_in) : VB'(in_value_in);
    s1_full_r    <= (MEAN_ONLY != 0) ? CB'(1) : CB'(full_h) * CB'(full_w);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: clipped spans; scale the magnitude by the full tap count.
  // ---------------------------------------------------------------------------
  logic                s2_valid_r;
  logic [TB-1:0]       s2_span_h_r, s2_span_w_r;
  logic [NUM_W-1:0]    s2_prod_r;
  logic                s2_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_span_h_r <= clip_span(s1_start_h_r, kk_h, pad_h_r, in_height_r);
    s2_span_w_r <= clip_span(s1_start_w_r, kk_w, pad_w_r, in_width_r);
    s2_prod_r   <= NUM_W'(s1_mag_r) * NUM_W'(s1_full_r);
    s2_neg_r    <= s1_neg_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: valid dilated tap count per axis (held at one for empty spans).
  // ---------------------------------------------------------------------------
  logic                s3_valid_r;
  logic [TB-1:0]       s3_hc_r, s3_wc_r;
  logic [NUM_W-1:0]    s3_prod_r;
  logic                s3_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_hc_r   <= wcr_pkg::tap_count(s2_span_h_r, DIL_H);
    s3_wc_r   <= wcr_pkg::tap_count(s2_span_w_r, DIL_W);
    s3_prod_r <= s2_prod_r;
    s3_neg_r  <= s2_neg_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: build the rounding dividend 2*mag*full + den and divisor 2*den.
  // ---------------------------------------------------------------------------
  wcr_pkg::div_tag_t   s4_tag_r;
  logic [NUM_W-1:0]    s4_num_r;
  logic [DEN_W-1:0]    s4_den_r;
  logic [CB-1:0]       den;

  assign den = CB'(s3_hc_r) * CB'(s3_wc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_tag_r <= '0;
    end else begin
      s4_tag_r.valid <= s3_valid_r;
      s4_tag_r.neg   <= s3_neg_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_num_r <= {s3_prod_r[NUM_W-2:0], 1'b0} + NUM_W'(den);
    s4_den_r <= {den, 1'b0};
  end

  // ---------------------------------------------------------------------------
  // Pipelined divider: one request per cycle.
  // ---------------------------------------------------------------------------
  wcr_pkg::div_tag_t   div_tag;
  logic [NUM_W-1:0]    div_quo;

  wcr_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .STEP  (wcr_pkg::DIV_STEP)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (s4_tag_r),
    .in_num  (s4_num_r),
    .in_den  (s4_den_r),
    .out_tag (div_tag),
    .out_quo (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Output stage: saturate the rounded magnitude, restore the sign.
  // ---------------------------------------------------------------------------
  logic                out_valid_r;
  logic [VB-1:0]       out_value_r;
  logic [VB-1:0]       res_nxt;

  always_comb begin
    if (div_tag.neg) begin
      if (div_quo > NUM_W'(40'h80_0000_0000 >> 8)) begin
        res_nxt = 32'h8000_0000;
      end else begin
        res_nxt = 32'd0 - div_quo[VB-1:0];
      end
    end else begin
      if (div_quo > NUM_W'(32'h7FFF_FFFF)) begin
        res_nxt = 32'h7FFF_FFFF;
      end else begin
        res_nxt = div_quo[VB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = $signed(out_value_r);

`ifndef NO_ASSERTIONS
  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept, LAT))
    else $error("result strobe without a request LAT cycles earlier");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s4_tag_r.valid |-> s4_den_r != '0)
    else $error("zero divisor entering divider");

  a_taps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_hc_r != '0) && (s3_hc_r <= full_h) &&
                   (s3_wc_r != '0) && (s3_wc_r <= full_w))
    else $error("valid tap count outside one..full");
`endif

endmodule

`default_nettype wire
